// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that cond never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- src/upl_pkg.sv -----
`timescale 1ns / 1ps

package upl_pkg;

	// Frame size limit, in bytes; anything past it is reported oversize
	localparam int unsigned MAX_FRAME_BYTES = 2048;

	localparam int unsigned POS_W     = 12;
	localparam int unsigned POS_LIMIT = (1 << POS_W) - 1;

	localparam int unsigned ETH_HDR   = 14;
	localparam int unsigned IP_MIN    = 20;
	localparam int unsigned UDP_HDR   = 8;
	localparam int unsigned MIN_FRAME = ETH_HDR + IP_MIN + UDP_HDR;

	// Byte indexes of fixed captures
	localparam int unsigned POS_ETYPE_HI = 12;
	localparam int unsigned POS_ETYPE_LO = 13;
	localparam int unsigned POS_VER_IHL  = ETH_HDR;
	localparam int unsigned POS_PROTO    = ETH_HDR + 9;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VER4    = 4'd4;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_ETYPE     = 4'd2,
		ST_VERSION   = 4'd3,
		ST_HDR_LEN   = 4'd4,
		ST_NOT_UDP   = 4'd5,
		ST_UDP_LEN   = 4'd6,
		ST_TRUNCATED = 4'd7,
		ST_OVERSIZE  = 4'd8
	} status_t;

endpackage

// ----- src/udp_payload_locator_unit.sv -----
`timescale 1ns / 1ps
// UDP payload locator: takes an Ethernet frame one byte per beat (last_byte
// marks the final byte) and, for each frame, returns one result beat with a
// status, the UDP payload offset and the UDP payload length. It checks, in
// order: oversize (more than MAX_FRAME_BYTES bytes), frame under 42 bytes,
// ethertype not IPv4, IP version not 4, bad IPv4 header length, protocol not
// UDP, UDP length under 8, and truncation. Offset and length are zero unless
// the status is ok. A byte is taken every clock while out_ready keeps up;
// the result of a frame is formed from its last byte in the input register
// and is then held in the result register until it is taken.
`include "assert_macros.svh"

module udp_payload_locator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length
);

	localparam int unsigned PW = upl_pkg::POS_W;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// per-frame state
	logic [PW-1:0] byte_position_q;
	logic [15:0]   ether_type_q;
	logic [7:0]    ver_ihl_q;
	logic [7:0]    ip_proto_q;
	logic [15:0]   udp_len_q;
	logic          oversize_q;

	// result register
	logic                out_valid_q;
	upl_pkg::status_t    status_q;
	logic [6:0]          offset_q;
	logic [15:0]         plen_q;

	// next-state values
	logic [15:0] ether_type_n;
	logic [7:0]  ver_ihl_n;
	logic [7:0]  ip_proto_n;
	logic [15:0] udp_len_n;
	logic        oversize_n;
	logic [5:0]  ihl_cur;
	logic [5:0]  ihl_n;
	logic [PW-1:0] udp_hi_pos;
	logic [PW-1:0] udp_lo_pos;

	// judgement
	logic [PW:0]   total_len;
	logic [PW:0]   hdr_need;
	logic [16:0]   trunc_need;
	upl_pkg::status_t status_n;
	logic [6:0]    offset_n;
	logic [15:0]   plen_n;

	logic advance_s1;
	logic out_free;

	// handshake: the input register moves on unless it holds a last byte and a result is blocked
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!last_s1 || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	// capture fields at their byte indexes
	always_comb begin
		ether_type_n = ether_type_q;
		ver_ihl_n    = ver_ihl_q;
		ip_proto_n   = ip_proto_q;
		udp_len_n    = udp_len_q;
		ihl_cur      = {ver_ihl_q[3:0], 2'b00};
		udp_hi_pos   = PW'(upl_pkg::ETH_HDR + 4) + {{(PW-6){1'b0}}, ihl_cur};
		udp_lo_pos   = PW'(upl_pkg::ETH_HDR + 5) + {{(PW-6){1'b0}}, ihl_cur};
		oversize_n   = oversize_q ||
			(byte_position_q >= PW'(upl_pkg::MAX_FRAME_BYTES));

		if (byte_position_q == PW'(upl_pkg::POS_ETYPE_HI)) begin
			ether_type_n[15:8] = byte_s1;
		end else if (byte_position_q == PW'(upl_pkg::POS_ETYPE_LO)) begin
			ether_type_n[7:0] = byte_s1;
		end else if (byte_position_q == PW'(upl_pkg::POS_VER_IHL)) begin
			ver_ihl_n = byte_s1;
		end else if (byte_position_q == PW'(upl_pkg::POS_PROTO)) begin
			ip_proto_n = byte_s1;
		end

		if (byte_position_q > PW'(upl_pkg::ETH_HDR)) begin
			if (byte_position_q == udp_hi_pos) begin
				udp_len_n[15:8] = byte_s1;
			end else if (byte_position_q == udp_lo_pos) begin
				udp_len_n[7:0] = byte_s1;
			end
		end
	end

	// check the frame on its last byte; the first failing check wins
	always_comb begin
		ihl_n      = {ver_ihl_n[3:0], 2'b00};
		total_len  = {1'b0, byte_position_q} + (PW+1)'(1);
		hdr_need   = (PW+1)'(upl_pkg::ETH_HDR + upl_pkg::UDP_HDR)
			+ {{(PW-5){1'b0}}, ihl_n};
		trunc_need = 17'(upl_pkg::ETH_HDR) + {11'b0, ihl_n} + {1'b0, udp_len_n};
		offset_n   = 7'd0;
		plen_n     = 16'd0;
		priority if (oversize_n) begin
			status_n = upl_pkg::ST_OVERSIZE;
		end else if (total_len < (PW+1)'(upl_pkg::MIN_FRAME)) begin
			status_n = upl_pkg::ST_SHORT;
		end else if (ether_type_n != upl_pkg::ETYPE_IPV4) begin
			status_n = upl_pkg::ST_ETYPE;
		end else if (ver_ihl_n[7:4] != upl_pkg::IP_VER4) begin
			status_n = upl_pkg::ST_VERSION;
		end else if (ihl_n < 6'(upl_pkg::IP_MIN) || total_len < hdr_need) begin
			status_n = upl_pkg::ST_HDR_LEN;
		end else if (ip_proto_n != upl_pkg::PROTO_UDP) begin
			status_n = upl_pkg::ST_NOT_UDP;
		end else if (udp_len_n < 16'(upl_pkg::UDP_HDR)) begin
			status_n = upl_pkg::ST_UDP_LEN;
		end else if ({{(16-PW){1'b0}}, total_len} < trunc_need) begin
			status_n = upl_pkg::ST_TRUNCATED;
		end else begin
			status_n = upl_pkg::ST_OK;
			offset_n = 7'(upl_pkg::ETH_HDR + upl_pkg::UDP_HDR) + {1'b0, ihl_n};
			plen_n   = udp_len_n - 16'(upl_pkg::UDP_HDR);
		end
	end

	// input register: hold while blocked, load on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	// frame state: advance per byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			ether_type_q    <= '0;
			ver_ihl_q       <= '0;
			ip_proto_q      <= '0;
			udp_len_q       <= '0;
			oversize_q      <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1) begin
				byte_position_q <= '0;
				ether_type_q    <= '0;
				ver_ihl_q       <= '0;
				ip_proto_q      <= '0;
				udp_len_q       <= '0;
				oversize_q      <= 1'b0;
			end else begin
				if (byte_position_q != PW'(upl_pkg::POS_LIMIT)) begin
					byte_position_q <= byte_position_q + PW'(1);
				end
				ether_type_q <= ether_type_n;
				ver_ihl_q    <= ver_ihl_n;
				ip_proto_q   <= ip_proto_n;
				udp_len_q    <= udp_len_n;
				oversize_q   <= oversize_n;
			end
		end
	end

	// result register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			status_q <= status_n;
			offset_q <= offset_n;
			plen_q   <= plen_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_offset = offset_q;
	assign payload_length = plen_q;

	// a good frame always has at least a minimal IPv4 header ahead of its payload
	`ASSERT_CLK(a_ok_offset, clk, arst_n,
		(out_valid_q && status_q == upl_pkg::ST_OK) |->
		(offset_q >= 7'(upl_pkg::MIN_FRAME)))

	// failed frames carry no location
	`ASSERT_CLK(a_fail_zero, clk, arst_n,
		(out_valid_q && status_q != upl_pkg::ST_OK) |->
		(offset_q == 7'd0 && plen_q == 16'd0))

	// the oversize mark only follows a position past the limit
	`ASSERT_CLK(a_oversize_pos, clk, arst_n,
		oversize_q |-> (byte_position_q >= PW'(upl_pkg::MAX_FRAME_BYTES)))

	// a last byte never overwrites a result that is still waiting
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n,
		advance_s1 && last_s1 && out_valid_q && !out_ready)

endmodule
